// ===== sv/burning_ship_escape_time_core_macros.svh =====
// Assertion macros shared by the escape-time core.
// Each macro expects clk and rst to be visible where it is used.
`ifndef BURNING_SHIP_ESCAPE_TIME_CORE_MACROS_SVH
`define BURNING_SHIP_ESCAPE_TIME_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define BSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define BSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/bse_pkg.sv =====
// Package for the escape-time core: payload structs, register indexes,
// fixed-point constants and the 32-bit saturation helper. No dependencies.
package bse_pkg;

  localparam int FRAC_BITS = 28;
  localparam int SAT_W     = 44;

  // |z|^2 bound of 4 in Q8.56
  localparam logic [63:0] ESCAPE_BOUND = 64'd4 << (2 * FRAC_BITS);

  // Configuration register indexes
  localparam logic [1:0] REG_ORIGIN_REAL     = 2'd0;
  localparam logic [1:0] REG_ORIGIN_IMAG     = 2'd1;
  localparam logic [1:0] REG_PIXEL_STEP      = 2'd2;
  localparam logic [1:0] REG_ITERATION_LIMIT = 2'd3;

  // Reset values of the registers
  localparam logic signed [31:0] ORIGIN_REAL_RST     = -32'sd671088640;
  localparam logic signed [31:0] ORIGIN_IMAG_RST     = -32'sd536870912;
  localparam logic [30:0]        PIXEL_STEP_RST      = 31'd917504;
  localparam logic [15:0]        ITERATION_LIMIT_RST = 16'd100;

  typedef struct packed {
    logic [9:0] column;
    logic [9:0] row;
  } bse_in_t;

  typedef struct packed {
    logic [15:0] iteration_count;
    logic [9:0]  out_column;
    logic [9:0]  out_row;
  } bse_out_t;

  // Clamp a wide signed value into signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(32'sh7FFF_FFFF);
    lo = -(SAT_W'(33'sh0_8000_0000));
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

// ===== sv/bse_mul.sv =====
// Shared 32x32 signed multiplier with a registered 64-bit product.
// Depends on nothing; operands are chosen by the sequencer in the top level.
module bse_mul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] prod
);

  // One product per cycle, available the cycle after the operands
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// ===== sv/bse_zupd.sv =====
// Burning Ship z update and escape test, combinational.
// Depends on bse_pkg for the saturation helper and the escape bound.
module bse_zupd (
  input  logic        [62:0] rr,
  input  logic        [62:0] ii,
  input  logic signed [63:0] rx,
  input  logic signed [31:0] cr,
  input  logic signed [31:0] ci,
  output logic signed [31:0] zr_new,
  output logic signed [31:0] zi_new,
  output logic               escaped
);
  import bse_pkg::*;

  logic signed [63:0] re_sum;
  logic signed [63:0] cr_scaled;
  logic        [63:0] rx_mag;
  logic        [35:0] cross_mag;
  logic signed [SAT_W-1:0] im_sum;
  logic        [63:0] mag_sum;

  // Real part: rr - ii + cr in Q8.56, floor shift back to Q4.28
  assign cr_scaled = {{4{cr[31]}}, cr, 28'd0};
  assign re_sum    = $signed({1'b0, rr}) - $signed({1'b0, ii}) + cr_scaled;
  assign zr_new    = sat32({{(SAT_W - 36){re_sum[63]}}, re_sum[63:28]});

  // Imaginary part: |2 zr zi| + ci, magnitude fits in 63 bits
  assign rx_mag    = rx[63] ? 64'(-rx) : 64'(rx);
  assign cross_mag = rx_mag[62:27];
  assign im_sum    = $signed({{(SAT_W - 36){1'b0}}, cross_mag}) +
                     $signed({{(SAT_W - 32){ci[31]}}, ci});
  assign zi_new    = sat32(im_sum);

  // Escape once |z|^2 exceeds 4
  assign mag_sum = {1'b0, rr} + {1'b0, ii};
  assign escaped = mag_sum > ESCAPE_BOUND;

endmodule

// ===== sv/burning_ship_escape_time_core.sv =====
// Burning Ship escape-time core: one pixel transaction in, one count out.
// It forms c, then iterates on the shared multiplier (3 products + update
// + check), then loads the output register; the loop runs count + 1 times
// on escape, else the limit. One pixel at a time: the next one is taken
// once the result is loaded, later if a stalled result holds the output.
// Synchronous active-high reset restores the register defaults and idles.
`include "burning_ship_escape_time_core_macros.svh"

module burning_ship_escape_time_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  bse_pkg::bse_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output bse_pkg::bse_out_t out_data
);
  import bse_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CR   = 4'd1;
  localparam logic [3:0] S_CI   = 4'd2;
  localparam logic [3:0] S_INIT = 4'd3;
  localparam logic [3:0] S_UPD  = 4'd4;
  localparam logic [3:0] S_M1   = 4'd5;
  localparam logic [3:0] S_M2   = 4'd6;
  localparam logic [3:0] S_M3   = 4'd7;
  localparam logic [3:0] S_CHK  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  logic signed [31:0] origin_real;
  logic signed [31:0] origin_imag;
  logic        [30:0] pixel_step;
  logic        [15:0] iteration_limit;

  logic [9:0]  column;
  logic [9:0]  row;
  logic [15:0] n;
  logic [15:0] n_inc;

  logic signed [31:0] cr;
  logic signed [31:0] ci;
  logic signed [31:0] zr;
  logic signed [31:0] zi;
  logic        [62:0] rr;
  logic        [62:0] ii;
  logic signed [63:0] rx;

  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] prod;
  logic signed [31:0] zr_new;
  logic signed [31:0] zi_new;
  logic               escaped;
  logic               out_free;
  logic               out_load;
  logic               in_loop;
  logic signed [31:0] c_sat_real;
  logic signed [31:0] c_sat_imag;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign out_load = (state == S_DONE) && out_free;
  assign n_inc    = n + 16'd1;
  assign in_loop  = (state == S_UPD) || (state == S_M1) || (state == S_M2) ||
                    (state == S_M3) || (state == S_CHK);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_real     <= ORIGIN_REAL_RST;
      origin_imag     <= ORIGIN_IMAG_RST;
      pixel_step      <= PIXEL_STEP_RST;
      iteration_limit <= ITERATION_LIMIT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ORIGIN_REAL:     origin_real     <= cfg_data;
        REG_ORIGIN_IMAG:     origin_imag     <= cfg_data;
        REG_PIXEL_STEP:      pixel_step      <= cfg_data[30:0];
        REG_ITERATION_LIMIT: iteration_limit <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_CR: begin
        mul_a = $signed({22'd0, column});
        mul_b = $signed({1'b0, pixel_step});
      end
      S_CI: begin
        mul_a = $signed({22'd0, row});
        mul_b = $signed({1'b0, pixel_step});
      end
      S_M1: begin
        mul_a = zr;
        mul_b = zr;
      end
      S_M2: begin
        mul_a = zi;
        mul_b = zi;
      end
      S_M3: begin
        mul_a = zr;
        mul_b = zi;
      end
      default: ;
    endcase
  end

  bse_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  bse_zupd u_zupd (
    .rr      (rr),
    .ii      (ii),
    .rx      (rx),
    .cr      (cr),
    .ci      (ci),
    .zr_new  (zr_new),
    .zi_new  (zi_new),
    .escaped (escaped)
  );

  // c = origin + coord*step; the product is non-negative and below 2^42
  assign c_sat_real = sat32($signed({{(SAT_W - 32){origin_real[31]}}, origin_real}) +
                            $signed(prod[SAT_W-1:0]));
  assign c_sat_imag = sat32($signed({{(SAT_W - 32){origin_imag[31]}}, origin_imag}) +
                            $signed(prod[SAT_W-1:0]));

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_CR;
      S_CR:   state_next = S_CI;
      S_CI:   state_next = S_INIT;
      S_INIT: state_next = (iteration_limit == 16'd0) ? S_DONE : S_UPD;
      S_UPD:  state_next = S_M1;
      S_M1:   state_next = S_M2;
      S_M2:   state_next = S_M3;
      S_M3:   state_next = S_CHK;
      S_CHK: begin
        if (escaped || (n_inc == iteration_limit)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_UPD;
        end
      end
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        column <= in_data.column;
        row    <= in_data.row;
      end
      S_CI:   cr <= c_sat_real;
      S_INIT: begin
        ci <= c_sat_imag;
        rr <= '0;
        ii <= '0;
        rx <= '0;
        n  <= '0;
      end
      S_UPD: begin
        zr <= zr_new;
        zi <= zi_new;
      end
      S_M2:   rr <= prod[62:0];
      S_M3:   ii <= prod[62:0];
      S_CHK: begin
        rx <= prod;
        if (!escaped) n <= n_inc;
      end
      default: ;
    endcase
  end

  // Output register; frees as soon as the result transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_data.iteration_count <= n;
      out_data.out_column      <= column;
      out_data.out_row         <= row;
    end
  end

  `BSE_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state == S_CR, "no setup after accept")
  `BSE_ASSERT_NOW(a_count_below_limit, in_loop, n < iteration_limit, "count at limit in loop")
  `BSE_ASSERT_NOW(a_square_nonneg, state == S_M3, !prod[63], "square product negative")
  `BSE_ASSERT_NEXT(a_result_loaded, out_load, out_valid && state == S_IDLE, "result not loaded")

endmodule

// ===== verif/tb_burning_ship_escape_time_core.sv =====
// Testbench for the Burning Ship escape-time core: a directed table, then random views,
// checked on typed counts or a fixed-point escape-count predictor. Needs bse_pkg, core.
module tb_burning_ship_escape_time_core;
  timeunit 1ns;
  timeprecision 1ps;
  import bse_pkg::*;

  localparam int HALF_PERIOD = 4;
  localparam int RESET_CYCLES = 6;
  localparam int RANDOM_ITEMS = 930;
  localparam int TAIL_CYCLES = 40;
  localparam longint MAX_CYCLES = 10_000_000;
  localparam longint Q428_MAX = 64'sd2147483647;
  localparam longint Q428_MIN = -64'sd2147483648;
  localparam int unsigned SENDER_IDLE_PCT [3] = '{21, 70, 0};
  localparam int unsigned RECEIVER_IDLE_PCT [3] = '{70, 21, 0};

  typedef enum logic {ROW_WRITE, ROW_PIXEL} dir_op_e;
  typedef enum int {VIEW_SHIP, VIEW_NOISE, VIEW_FAST} view_e;

  typedef struct packed {
    dir_op_e     op;
    logic [1:0]  index;
    logic [31:0] data;
    bse_in_t     pixel;
    logic        known;
    logic [15:0] count;
  } dir_row_t;

  // Directed table: register writes and pixels, expected count typed where obvious
  localparam dir_row_t DIRECTED_ROWS [39] = '{
    // reset view, corner at (-2.5, -2.0) escapes on the first update
    '{ROW_PIXEL, '0, '0, {10'd0, 10'd0}, 1'b1, 16'd0},
    '{ROW_PIXEL, '0, '0, {10'd1023, 10'd1023}, 1'b0, 16'd0},
    '{ROW_PIXEL, '0, '0, {10'd731, 10'd585}, 1'b0, 16'd0},
    '{ROW_PIXEL, '0, '0, {10'd1023, 10'd0}, 1'b0, 16'd0},
    '{ROW_PIXEL, '0, '0, {10'd0, 10'd1023}, 1'b0, 16'd0},
    '{ROW_PIXEL, '0, '0, {10'h2AA, 10'h155}, 1'b0, 16'd0},
    '{ROW_PIXEL, '0, '0, {10'h155, 10'h2AA}, 1'b0, 16'd0},
    // c = 0 never escapes: count equals the limit
    '{ROW_WRITE, REG_ORIGIN_REAL, 32'h0000_0000, '0, 1'b0, 16'd0},
    '{ROW_WRITE, REG_ORIGIN_IMAG, 32'h0000_0000, '0, 1'b0, 16'd0},
    '{ROW_WRITE, REG_PIXEL_STEP, 32'h0000_0000, '0, 1'b0, 16'd0},
    '{ROW_PIXEL, '0, '0, {10'd1023, 10'd1023}, 1'b1, 16'd100},
    // zero limit, then a limit of one
    '{ROW_WRITE, REG_ITERATION_LIMIT, 32'h0000_0000, '0, 1'b0, 16'd0},
    '{ROW_PIXEL, '0, '0, {10'd0, 10'd0}, 1'b1, 16'd0},
    '{ROW_PIXEL, '0, '0, {10'd1023, 10'd1023}, 1'b1, 16'd0},
    '{ROW_WRITE, REG_ITERATION_LIMIT, 32'h0000_0001, '0, 1'b0, 16'd0},
    '{ROW_PIXEL, '0, '0, {10'd5, 10'd5}, 1'b1, 16'd1},
    // |z|^2 exactly 4 does not escape: c = 2 escapes one update later, c = -2 never
    '{ROW_WRITE, REG_ITERATION_LIMIT, 32'h0000_0032, '0, 1'b0, 16'd0},
    '{ROW_WRITE, REG_ORIGIN_REAL, 32'h2000_0000, '0, 1'b0, 16'd0},
    '{ROW_PIXEL, '0, '0, {10'd9, 10'd9}, 1'b1, 16'd1},
    '{ROW_WRITE, REG_ORIGIN_REAL, 32'hE000_0000, '0, 1'b0, 16'd0},
    '{ROW_PIXEL, '0, '0, {10'd9, 10'd9}, 1'b1, 16'd50},
    // largest limit with c far outside, c saturated at the top of the range
    '{ROW_WRITE, REG_ITERATION_LIMIT, 32'h0000_FFFF, '0, 1'b0, 16'd0},
    '{ROW_WRITE, REG_ORIGIN_REAL, 32'h2800_0000, '0, 1'b0, 16'd0},
    '{ROW_WRITE, REG_ORIGIN_IMAG, 32'h7FFF_FFFF, '0, 1'b0, 16'd0},
    '{ROW_WRITE, REG_PIXEL_STEP, 32'h7FFF_FFFF, '0, 1'b0, 16'd0},
    '{ROW_PIXEL, '0, '0, {10'd0, 10'd0}, 1'b1, 16'd0},
    '{ROW_PIXEL, '0, '0, {10'd1023, 10'd1023}, 1'b1, 16'd0},
    // most negative origins, step bit 31 dropped so the step is zero
    '{ROW_WRITE, REG_ORIGIN_REAL, 32'h8000_0000, '0, 1'b0, 16'd0},
    '{ROW_WRITE, REG_ORIGIN_IMAG, 32'h8000_0000, '0, 1'b0, 16'd0},
    '{ROW_WRITE, REG_PIXEL_STEP, 32'h8000_0000, '0, 1'b0, 16'd0},
    '{ROW_PIXEL, '0, '0, {10'd1023, 10'd0}, 1'b1, 16'd0},
    '{ROW_WRITE, REG_PIXEL_STEP, 32'h7FFF_FFFF, '0, 1'b0, 16'd0},
    '{ROW_PIXEL, '0, '0, {10'd1023, 10'd1}, 1'b1, 16'd0},
    // zoom near the small ship, long limit
    '{ROW_WRITE, REG_ITERATION_LIMIT, 32'd1000, '0, 1'b0, 16'd0},
    '{ROW_WRITE, REG_ORIGIN_REAL, -32'sd483183821, '0, 1'b0, 16'd0},
    '{ROW_WRITE, REG_ORIGIN_IMAG, -32'sd26843546, '0, 1'b0, 16'd0},
    '{ROW_WRITE, REG_PIXEL_STEP, 32'd262144, '0, 1'b0, 16'd0},
    '{ROW_PIXEL, '0, '0, {10'd0, 10'd0}, 1'b0, 16'd0},
    '{ROW_PIXEL, '0, '0, {10'd50, 10'd70}, 1'b0, 16'd0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = REG_ORIGIN_REAL;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  bse_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  bse_out_t    out_data;

  // Local copy of the configuration registers
  int          cur_origin_real;
  int          cur_origin_imag;
  bit [30:0]   cur_pixel_step;
  bit [15:0]   cur_iteration_limit;

  bse_out_t    pending_counts [$];
  bse_out_t    oldest_count;
  int unsigned sender_idle_pct = SENDER_IDLE_PCT[0];
  int unsigned receiver_idle_pct = RECEIVER_IDLE_PCT[0];
  int          failures = 0;
  longint      cycle_count = 0;

  burning_ship_escape_time_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Clamp to signed Q4.28
  function automatic longint clamp_q428(input longint v);
    if (v > Q428_MAX) return Q428_MAX;
    if (v < Q428_MIN) return Q428_MIN;
    return v;
  endfunction

  // Iterations of the burning ship map before |z|^2 exceeds 4
  function automatic logic [15:0] escape_iterations(input longint cr, input longint ci,
                                                    input logic [15:0] limit);
    longint zr;
    longint zi;
    longint re;
    longint cross_mag;
    longint unsigned mag;
    int unsigned n;
    zr = 0;
    zi = 0;
    n = 0;
    while (n < limit) begin
      re = zr * zr - zi * zi + (cr <<< FRAC_BITS);
      cross_mag = zr * zi;
      if (cross_mag < 0) cross_mag = -cross_mag;
      zr = clamp_q428(re >>> FRAC_BITS);
      zi = clamp_q428((cross_mag >> (FRAC_BITS - 1)) + ci);
      mag = zr * zr;
      mag = mag + longint'(zi * zi);
      if (mag > ESCAPE_BOUND) break;
      n++;
    end
    return 16'(n);
  endfunction

  // Expected result of one pixel under the current registers
  function automatic bse_out_t pixel_result(input bse_in_t px);
    longint cr;
    longint ci;
    bse_out_t res;
    cr = clamp_q428(longint'(cur_origin_real) +
                    longint'(px.column) * longint'(cur_pixel_step));
    ci = clamp_q428(longint'(cur_origin_imag) +
                    longint'(px.row) * longint'(cur_pixel_step));
    res.iteration_count = escape_iterations(cr, ci, cur_iteration_limit);
    res.out_column = px.column;
    res.out_row = px.row;
    return res;
  endfunction

  function automatic void apply_register(input logic [1:0] index, input logic [31:0] data);
    case (index)
      REG_ORIGIN_REAL: cur_origin_real = data;
      REG_ORIGIN_IMAG: cur_origin_imag = data;
      REG_PIXEL_STEP: cur_pixel_step = data[30:0];
      REG_ITERATION_LIMIT: cur_iteration_limit = data[15:0];
      default: ;
    endcase
  endfunction

  task automatic write_register(input logic [1:0] index, input logic [31:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    apply_register(index, data);
  endtask

  // Offer one pixel transaction, with random gaps, and wait until it is taken
  task automatic send_pixel(input bse_in_t px, input bse_out_t want);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_counts.push_back(want);
  endtask

  // Hold off the sender until every outstanding count has come back
  task automatic drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_counts.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_counts.size() == 0) begin
        $error("unexpected result: count %0d column %0d row %0d",
               out_data.iteration_count, out_data.out_column, out_data.out_row);
        failures++;
      end else begin
        oldest_count = pending_counts.pop_front();
        if (out_data.iteration_count !== oldest_count.iteration_count) begin
          $error("iteration_count: expected %0d, actual %0d",
                 oldest_count.iteration_count, out_data.iteration_count);
          failures++;
        end
        if (out_data.out_column !== oldest_count.out_column) begin
          $error("out_column: expected %0d, actual %0d",
                 oldest_count.out_column, out_data.out_column);
          failures++;
        end
        if (out_data.out_row !== oldest_count.out_row) begin
          $error("out_row: expected %0d, actual %0d",
                 oldest_count.out_row, out_data.out_row);
          failures++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("burning_ship_escape_time_core regression: fail");
      $finish;
    end
  end

  initial begin
    bse_in_t     px;
    bse_out_t    want;
    view_e       view;
    int unsigned pick;
    int unsigned batch;
    int unsigned sent;
    logic [31:0] w_real;
    logic [31:0] w_imag;
    logic [31:0] w_step;
    logic [31:0] w_limit;

    cur_origin_real = ORIGIN_REAL_RST;
    cur_origin_imag = ORIGIN_IMAG_RST;
    cur_pixel_step = PIXEL_STEP_RST;
    cur_iteration_limit = ITERATION_LIMIT_RST;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].op == ROW_WRITE) begin
        drain_pipeline();
        write_register(DIRECTED_ROWS[i].index, DIRECTED_ROWS[i].data);
      end else begin
        px = DIRECTED_ROWS[i].pixel;
        if (DIRECTED_ROWS[i].known) begin
          want.iteration_count = DIRECTED_ROWS[i].count;
          want.out_column = px.column;
          want.out_row = px.row;
        end else begin
          want = pixel_result(px);
        end
        send_pixel(px, want);
      end
    end

    // Random views, three idle settings
    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = SENDER_IDLE_PCT[ph];
      receiver_idle_pct = RECEIVER_IDLE_PCT[ph];
      sent = 0;
      while (sent < RANDOM_ITEMS / 3) begin
        drain_pipeline();
        pick = $urandom_range(0, 99);
        view = (pick < 60) ? VIEW_SHIP : (pick < 85) ? VIEW_NOISE : VIEW_FAST;
        case (view)
          // window over the ship, small limits mostly
          VIEW_SHIP: begin
            w_real = int'($urandom_range(0, 939524096)) - 671088640;
            w_imag = int'($urandom_range(0, 805306368)) - 536870912;
            w_step = $urandom_range(1 << 10, 1 << 20);
            w_limit = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 255)
                                                  : $urandom_range(1, 64);
          end
          // any register bits, short limit
          VIEW_NOISE: begin
            w_real = $urandom();
            w_imag = $urandom();
            w_step = $urandom();
            w_limit = ($urandom() & 32'hFFFF_0000) | $urandom_range(0, 64);
          end
          // real part of c at least 2.5: escapes at once, so any limit is cheap
          default: begin
            w_real = $urandom_range(32'h2800_0000, 32'h7FFF_FFFF);
            w_imag = $urandom();
            w_step = $urandom();
            w_limit = $urandom();
          end
        endcase
        write_register(REG_ORIGIN_REAL, w_real);
        write_register(REG_ORIGIN_IMAG, w_imag);
        write_register(REG_PIXEL_STEP, w_step);
        write_register(REG_ITERATION_LIMIT, w_limit);
        batch = $urandom_range(15, 40);
        repeat (batch) begin
          px.column = $urandom_range(0, 1023);
          px.row = $urandom_range(0, 1023);
          send_pixel(px, pixel_result(px));
          sent++;
        end
      end
    end

    drain_pipeline();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (failures == 0) begin
      $display("burning_ship_escape_time_core regression: pass");
    end else begin
      $display("burning_ship_escape_time_core regression: fail");
    end
    $finish;
  end

endmodule
